FILE: src/chunk_fill_lru_file_cache_macros.svh
// Assertion helpers for the LRU file cache.
`ifndef CHUNK_FILL_LRU_FILE_CACHE_MACROS_SVH
`define CHUNK_FILL_LRU_FILE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define CFLC_ASSERT_NOW(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define CFLC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CFLC_ASSERT_NOW(label, clk, rstn, cond, msg)
`define CFLC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/cflc_pkg.sv
`timescale 1ns / 1ps
package cflc_pkg;
    localparam int SLOTS_DEF     = 64;
    localparam int CHUNK_MAX_DEF = 16;
    localparam int ID_W          = 32;
    localparam int KIND_W        = 3;
    localparam int SLOT_OUT_W    = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT       = 3'd0,
        KIND_MISS      = 3'd1,
        KIND_EVICT     = 3'd2,
        KIND_ALLOC     = 3'd3,
        KIND_NOTHING   = 3'd4,
        KIND_TOO_LARGE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECIDE = 3'b010,
        ST_WALK   = 3'b100
    } state_t;

    typedef struct packed {
        logic            cmp_en;
        logic            touch_en;
        logic            rotate_en;
        logic            alloc_en;
        logic [ID_W-1:0] cmp_id;
        logic [ID_W-1:0] wr_tag;
    } cell_ctrl_t;
endpackage

FILE: src/cflc_cell.sv
`timescale 1ns / 1ps
module cflc_cell import cflc_pkg::*; #(
    parameter int SW    = 6,
    parameter int INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cell_ctrl_t      ctrl,
    input  logic [SW-1:0]   touch_slot,
    input  logic            pre_in,
    input  logic            left_valid,
    input  logic            right_valid,
    input  logic [SW-1:0]   right_slot,
    input  logic [ID_W-1:0] right_tag,
    output logic            pre_out,
    output logic            match,
    output logic            valid,
    output logic [SW-1:0]   slot,
    output logic [ID_W-1:0] tag
);
    logic            valid_reg, match_reg;
    logic [SW-1:0]   slot_reg;
    logic [ID_W-1:0] tag_reg;

    assign pre_out = pre_in | match_reg;
    assign match   = match_reg;
    assign valid   = valid_reg;
    assign slot    = slot_reg;
    assign tag     = tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            slot_reg  <= SW'(INDEX);
        end else begin
            if (ctrl.cmp_en) begin
                match_reg <= valid_reg && (tag_reg == ctrl.cmp_id);
            end
            if (ctrl.touch_en && pre_out && valid_reg) begin
                // shift toward oldest; the newest position takes the touched slot
                if (right_valid) begin
                    slot_reg <= right_slot;
                end else begin
                    slot_reg <= touch_slot;
                end
            end else if (ctrl.rotate_en) begin
                slot_reg  <= right_slot;
                valid_reg <= right_valid;
            end else if (ctrl.alloc_en && !valid_reg && left_valid) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.touch_en && pre_out && valid_reg) begin
            tag_reg <= right_valid ? right_tag : ctrl.wr_tag;
        end else if (ctrl.rotate_en) begin
            tag_reg <= right_tag;
        end else if (ctrl.alloc_en && !valid_reg && left_valid) begin
            tag_reg <= ctrl.wr_tag;
        end
    end
endmodule

FILE: src/chunk_fill_lru_file_cache.sv
`timescale 1ns / 1ps
// Lookup: the tag compare across the cell chain is registered when the request is accepted;
// the answer is loaded into the output register together with the relink step.
// Fill item: the id is checked and queued. The last fill item is followed by its results
// (each eviction and allocation, or the single nothing-new or too-large result),
// walked one result per cycle through the output register while the output does not stall.
// Reset (aresetn low, synchronous) empties the cache, restores ring order and
// clears the pending queue at once; no clearing pass.
`include "chunk_fill_lru_file_cache_macros.svh"
module chunk_fill_lru_file_cache import cflc_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [ID_W-1:0]       s_file_id,
    input  logic                  s_last_in_chunk,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIND_W-1:0]     m_kind,
    output logic [SLOT_OUT_W-1:0] m_slot_index,
    output logic [ID_W-1:0]       m_file_id_out,
    output logic                  m_last_result
);
    localparam int SW     = $clog2(SLOTS);
    localparam int UW     = $clog2(SLOTS + 1);
    localparam int QLIMIT = (CHUNK_MAX < SLOTS) ? CHUNK_MAX : SLOTS;
    localparam int PCW    = $clog2(QLIMIT + 1);

    // Cell chain: position 0 is the oldest entry; valid cells form a prefix.
    cell_ctrl_t      ctrl;
    logic [SW-1:0]   slot_w  [SLOTS];
    logic [ID_W-1:0] tag_w   [SLOTS];
    logic            valid_w [SLOTS];
    logic [SLOTS-1:0] match_w;
    logic [SLOTS:0]  pre_w;
    logic [SW-1:0]   touch_slot;
    logic [SW-1:0]   open_slot;

    assign pre_w[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic          lv, rv;
        logic [SW-1:0] rs;
        logic [ID_W-1:0] rt;
        if (i == 0) begin : g_first
            assign lv = 1'b1;
        end else begin : g_mid
            assign lv = valid_w[i-1];
        end
        if (i == SLOTS - 1) begin : g_last
            // wrap the oldest entry around as a free slot on rotation
            assign rv = 1'b0;
            assign rs = slot_w[0];
            assign rt = tag_w[0];
        end else begin : g_body
            assign rv = valid_w[i+1];
            assign rs = slot_w[i+1];
            assign rt = tag_w[i+1];
        end
        cflc_cell #(.SW(SW), .INDEX(i)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .touch_slot  (touch_slot),
            .pre_in      (pre_w[i]),
            .left_valid  (lv),
            .right_valid (rv),
            .right_slot  (rs),
            .right_tag   (rt),
            .pre_out     (pre_w[i+1]),
            .match       (match_w[i]),
            .valid       (valid_w[i]),
            .slot        (slot_w[i]),
            .tag         (tag_w[i])
        );
    end

    // Tags are unique among valid cells, so an OR select picks the matching slot.
    always_comb begin
        touch_slot = '0;
        open_slot  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (match_w[i]) begin
                touch_slot = touch_slot | slot_w[i];
            end
            if (!valid_w[i] && ((i == 0) || valid_w[(i == 0) ? 0 : i - 1])) begin
                open_slot = open_slot | slot_w[i];
            end
        end
    end

    state_t          state_reg, state_next;
    logic            op_reg, last_reg, qhit_reg, ovf_reg, ovf_next;
    logic [ID_W-1:0] id_reg;
    logic [UW-1:0]   used_reg, used_next;
    logic [PCW-1:0]  pcount_reg, pcount_next;
    logic [ID_W-1:0] q_reg [QLIMIT];
    logic            push, pop, qhit;

    logic                  m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [KIND_W-1:0]     m_kind_reg, m_kind_next;
    logic [SW-1:0]         m_slot_reg, m_slot_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic [SLOT_OUT_W+SW-1:0] slot_ext;
    logic                  out_free, hit, need_evict, accept;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = |match_w;
    assign need_evict = ((UW+1)'(used_reg) + (UW+1)'(pcount_reg)) > (UW+1)'(SLOTS);

    always_comb begin
        qhit = 1'b0;
        for (int j = 0; j < QLIMIT; j++) begin
            if ((PCW'(j) < pcount_reg) && (q_reg[j] == s_file_id)) begin
                qhit = 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        ovf_next     = ovf_reg;
        used_next    = used_reg;
        pcount_next  = pcount_reg;
        push         = 1'b0;
        pop          = 1'b0;
        ctrl.cmp_en    = accept;
        ctrl.touch_en  = 1'b0;
        ctrl.rotate_en = 1'b0;
        ctrl.alloc_en  = 1'b0;
        ctrl.cmp_id    = s_file_id;
        ctrl.wr_tag    = id_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_slot_next  = m_slot_reg;
        m_id_next    = m_id_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!op_reg) begin
                    // lookup: answer and relink the hit entry to newest
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_kind_next   = hit ? KIND_HIT : KIND_MISS;
                        m_slot_next   = hit ? touch_slot : '0;
                        m_id_next     = id_reg;
                        m_last_next   = 1'b1;
                        ctrl.touch_en = hit;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    // fill: queue a new id, or flag the chunk once the queue is full
                    if (!ovf_reg && !hit && !qhit_reg) begin
                        if (pcount_reg >= PCW'(QLIMIT)) begin
                            ovf_next = 1'b1;
                        end else begin
                            push        = 1'b1;
                            pcount_next = pcount_reg + PCW'(1);
                        end
                    end
                    state_next = last_reg ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b0;
                    if (ovf_reg) begin
                        m_kind_next = KIND_TOO_LARGE;
                        m_slot_next = '0;
                        m_id_next   = '0;
                        m_last_next = 1'b1;
                        ovf_next    = 1'b0;
                        pcount_next = '0;
                        state_next  = ST_IDLE;
                    end else if (pcount_reg == '0) begin
                        m_kind_next = KIND_NOTHING;
                        m_slot_next = '0;
                        m_id_next   = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else if (need_evict) begin
                        // drop the oldest entry and rotate it to the free end
                        m_kind_next    = KIND_EVICT;
                        m_slot_next    = slot_w[0];
                        m_id_next      = tag_w[0];
                        ctrl.rotate_en = 1'b1;
                        used_next      = used_reg - UW'(1);
                    end else begin
                        m_kind_next   = KIND_ALLOC;
                        m_slot_next   = open_slot;
                        m_id_next     = q_reg[0];
                        ctrl.alloc_en = 1'b1;
                        ctrl.wr_tag   = q_reg[0];
                        pop           = 1'b1;
                        used_next     = used_reg + UW'(1);
                        pcount_next   = pcount_reg - PCW'(1);
                        if (pcount_reg == PCW'(1)) begin
                            m_last_next = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ovf_reg     <= 1'b0;
            used_reg    <= '0;
            pcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ovf_reg     <= ovf_next;
            used_reg    <= used_next;
            pcount_reg  <= pcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            id_reg   <= s_file_id;
            last_reg <= s_last_in_chunk;
            qhit_reg <= qhit;
        end
        m_kind_reg <= m_kind_next;
        m_slot_reg <= m_slot_next;
        m_id_reg   <= m_id_next;
        m_last_reg <= m_last_next;
        for (int j = 0; j < QLIMIT; j++) begin
            if (push && (pcount_reg == PCW'(j))) begin
                q_reg[j] <= id_reg;
            end else if (pop && (j < QLIMIT - 1)) begin
                q_reg[j] <= q_reg[(j < QLIMIT - 1) ? j + 1 : j];
            end
        end
    end

    assign slot_ext      = {{SLOT_OUT_W{1'b0}}, m_slot_reg};
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_slot_index  = slot_ext[SLOT_OUT_W-1:0];
    assign m_file_id_out = m_id_reg;
    assign m_last_result = m_last_reg;

    `CFLC_ASSERT_NOW(a_match_unique, aclk, aresetn, $onehot0(match_w), "duplicate tag match")
    `CFLC_ASSERT_NOW(a_used_bound, aclk, aresetn, used_reg <= UW'(SLOTS), "used count overflow")
    `CFLC_ASSERT_IMPL(a_walk_queue, aclk, aresetn, (state_reg == ST_WALK) && !ovf_reg && (pcount_reg != '0), pcount_reg <= PCW'(QLIMIT), "queue count out of range")
endmodule

FILE: tb/sv/chunk_fill_lru_file_cache_checker.sv
`timescale 1ns / 1ps
module chunk_fill_lru_file_cache_checker import cflc_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [ID_W-1:0]       s_file_id,
    input  logic                  s_last_in_chunk,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [KIND_W-1:0]     m_kind,
    input  logic [SLOT_OUT_W-1:0] m_slot_index,
    input  logic [ID_W-1:0]       m_file_id_out,
    input  logic                  m_last_result,
    output int                    fail_count,
    output int                    pending_results
);
    localparam int QLIM = (CHUNK_MAX < SLOTS) ? CHUNK_MAX : SLOTS;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       id;
        logic                  last;
    } cache_result_t;

    cache_result_t result_q[$];

    logic [ID_W-1:0] tag_m [SLOTS];
    bit              vld_m [SLOTS];
    int              nxt_m [SLOTS];
    int              prv_m [SLOTS];
    int              oldest_m, newest_m, used_m, pend_n;
    bit              empty_m, ovf_m;
    logic [ID_W-1:0] pend_m [QLIM];

    assign pending_results = result_q.size();

    function automatic int lookup_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (vld_m[i] && tag_m[i] == id) return i;
        return SLOTS;
    endfunction

    function automatic void push_result(kind_t k, int s, logic [ID_W-1:0] id);
        cache_result_t r;
        r.kind = k;
        r.slot = s[SLOT_OUT_W-1:0];
        r.id   = id;
        r.last = 1'b0;
        result_q.insert(result_q.size(), r);
    endfunction

    function automatic void move_to_newest(int s);
        int nx, pv, aft;
        if (s == newest_m) return;
        nx = nxt_m[s];
        pv = prv_m[s];
        prv_m[nx] = pv;
        nxt_m[pv] = nx;
        if (s == oldest_m) oldest_m = nx;
        aft = nxt_m[newest_m];
        nxt_m[s] = aft;
        prv_m[s] = newest_m;
        prv_m[aft] = s;
        nxt_m[newest_m] = s;
        newest_m = s;
    endfunction

    function automatic void close_chunk();
        int s, k;
        if (ovf_m) begin
            push_result(KIND_TOO_LARGE, 0, '0);
        end else if (pend_n == 0) begin
            push_result(KIND_NOTHING, 0, '0);
        end else begin
            if (pend_n > SLOTS - used_m) begin
                k = pend_n - (SLOTS - used_m);
                s = oldest_m;
                for (int i = 0; i < k; i++) begin
                    push_result(KIND_EVICT, s, tag_m[s]);
                    vld_m[s] = 0;
                    used_m--;
                    s = nxt_m[s];
                end
                oldest_m = s;
            end
            if (empty_m) begin
                oldest_m = 0;
                s = 0;
                empty_m = 0;
            end else begin
                s = nxt_m[newest_m];
            end
            for (int i = 0; i < pend_n; i++) begin
                tag_m[s] = pend_m[i];
                vld_m[s] = 1;
                used_m++;
                push_result(KIND_ALLOC, s, pend_m[i]);
                newest_m = s;
                s = nxt_m[s];
            end
        end
        pend_n = 0;
        ovf_m = 0;
        result_q[$].last = 1'b1;
    endfunction

    function automatic void predict_request(logic op, logic [ID_W-1:0] id, logic lst);
        int s;
        bit seen;
        if (op == 1'b0) begin
            s = lookup_slot(id);
            if (s < SLOTS) begin
                move_to_newest(s);
                push_result(KIND_HIT, s, id);
            end else begin
                push_result(KIND_MISS, 0, id);
            end
            result_q[$].last = 1'b1;
            return;
        end
        if (!ovf_m && lookup_slot(id) == SLOTS) begin
            seen = 0;
            for (int i = 0; i < pend_n; i++)
                if (pend_m[i] == id) seen = 1;
            if (!seen) begin
                if (pend_n >= QLIM) ovf_m = 1;
                else pend_m[pend_n++] = id;
            end
        end
        if (lst) close_chunk();
    endfunction

    always @(posedge aclk) begin
        cache_result_t e;
        if (!aresetn) begin
            result_q.delete();
            for (int i = 0; i < SLOTS; i++) begin
                vld_m[i] = 0;
                nxt_m[i] = (i + 1) % SLOTS;
                prv_m[i] = (i + SLOTS - 1) % SLOTS;
            end
            oldest_m = 0;
            newest_m = 0;
            empty_m = 1;
            used_m = 0;
            pend_n = 0;
            ovf_m = 0;
        end else begin
            // compare output first: a request is never answered in the cycle it is accepted
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d slot=%0d id=%h last=%0d",
                             $time, m_kind, m_slot_index, m_file_id_out, m_last_result);
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    if (m_kind !== e.kind || m_slot_index !== e.slot ||
                        m_file_id_out !== e.id || m_last_result !== e.last) begin
                        $display("%0t: mismatch expected kind=%0d slot=%0d id=%h last=%0d",
                                 $time, e.kind, e.slot, e.id, e.last);
                        $display("%0t:          actual   kind=%0d slot=%0d id=%h last=%0d",
                                 $time, m_kind, m_slot_index, m_file_id_out,
                                 m_last_result);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_request(s_opcode, s_file_id, s_last_in_chunk);
        end
    end

    initial fail_count = 0;
endmodule

FILE: tb/sv/chunk_fill_lru_file_cache_test.sv
`timescale 1ns / 1ps
module chunk_fill_lru_file_cache_test;
    import cflc_pkg::*;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_opcode;
    logic [ID_W-1:0]       s_file_id;
    logic                  s_last_in_chunk;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_W-1:0]     m_kind;
    logic [SLOT_OUT_W-1:0] m_slot_index;
    logic [ID_W-1:0]       m_file_id_out;
    logic                  m_last_result;
    int                    fail_count;
    int                    pending_results;

    // receiver stall controls: random pattern unless a long hold-off is requested
    bit hold_off;
    bit stall_free;

    // small pool of ids so lookups hit and fills overlap cached entries
    logic [ID_W-1:0] id_pool [64];

    chunk_fill_lru_file_cache uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_file_id(s_file_id), .s_last_in_chunk(s_last_in_chunk),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_slot_index(m_slot_index), .m_file_id_out(m_file_id_out),
        .m_last_result(m_last_result)
    );

    chunk_fill_lru_file_cache_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_file_id(s_file_id), .s_last_in_chunk(s_last_in_chunk),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_slot_index(m_slot_index), .m_file_id_out(m_file_id_out),
        .m_last_result(m_last_result),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Send one request: hold valid and payload until the handshake completes.
    task automatic send_request(logic op, logic [ID_W-1:0] id, logic lst);
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_file_id       <= id;
        s_last_in_chunk <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and idle for a number of cycles.
    task automatic idle_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Pick an id: mostly from the pool, sometimes fully random.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return id_pool[$urandom_range(0, 63)];
    endfunction

    // Receiver: random stall pattern, with stall-free and long hold-off stretches.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else if (stall_free) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        int burst;
        int csize;
        int sent;
        bit held_once;
        s_valid         <= 1'b0;
        s_opcode        <= OP_LOOKUP;
        s_file_id       <= '0;
        s_last_in_chunk <= 1'b0;
        aresetn         <= 1'b0;
        hold_off   = 0;
        stall_free = 0;
        held_once  = 0;
        for (int i = 0; i < 64; i++) id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-ring lookups, nothing-new fill, first allocation at slot zero
        send_request(OP_LOOKUP, 32'h0000_0000, 1'b0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_FILL, 32'h0000_0000, 1'b0);
        send_request(OP_FILL, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_FILL, 32'h0000_0000, 1'b0);   // already queued
        send_request(OP_LOOKUP, 32'h0000_0000, 1'b0); // lookup inside a chunk fill
        send_request(OP_FILL, 32'h5A5A_A5A5, 1'b1);
        send_request(OP_LOOKUP, 32'h5A5A_A5A5, 1'b0); // hit on newest
        send_request(OP_LOOKUP, 32'h0000_0000, 1'b0); // hit on oldest, relink
        send_request(OP_FILL, 32'hFFFF_FFFF, 1'b1);   // cached only: nothing new
        // overflow the queue: one more new id than a chunk may hold
        for (int i = 0; i < CHUNK_MAX_DEF + 1; i++)
            send_request(OP_FILL, 32'h1000_0000 + i, i == CHUNK_MAX_DEF);
        wait_drained();

        // random: mostly well-formed chunks and lookups, some oversized chunks
        sent = 0;
        while (sent < 150) begin
            stall_free = ($urandom_range(0, 4) == 0);
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                if ($urandom_range(0, 2) == 0) begin
                    csize = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20)
                                                        : $urandom_range(1, 10);
                    for (int c = 0; c < csize; c++)
                        send_request(OP_FILL, pick_id(), c == csize - 1);
                    sent += csize;
                end else begin
                    send_request(OP_LOOKUP, pick_id(), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            if ($urandom_range(0, 1) != 0) idle_sender($urandom_range(1, 8));
            if (sent > 60 && !held_once && !hold_off) begin
                // long receiver hold-off while the sender keeps offering
                held_once = 1;
                hold_off = 1;
                fork
                    begin
                        repeat (300) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            if (sent > 120 && sent < 140) wait_drained();
        end
        wait_drained();
        stall_free = 0;
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/cflc_pkg.sv
src/cflc_cell.sv
src/chunk_fill_lru_file_cache.sv
tb/sv/chunk_fill_lru_file_cache_checker.sv
tb/sv/chunk_fill_lru_file_cache_test.sv
